[hw/rtl/lorenz_pkg.sv]
// Shared types, constants and microcode for the Lorenz integrator.
// No dependencies; used by every other file of the block.
`default_nettype none
package lorenz_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 24;
    localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
    localparam int MQ_WIDTH    = PROD_WIDTH - FRAC_BITS;
    localparam int ADDR_WIDTH  = 5;
    localparam int PC_WIDTH    = 7;
    localparam int STEP_WIDTH  = 31;
    localparam int CFG_IDX_WIDTH = 3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [ADDR_WIDTH-1:0] addr_t;
    typedef logic [PC_WIDTH-1:0] pc_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    // reciprocal of six for truncating signed division
    localparam coord_t DIV6_MAGIC = 32'h2AAA_AAAB;

    localparam logic OPER_LOAD = 1'b0;
    localparam logic OPER_STEP = 1'b1;

    localparam logic METHOD_EULER = 1'b0;
    localparam logic METHOD_RK4   = 1'b1;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SIGMA  = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_RHO    = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_BETA   = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_STEP   = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_METHOD = 3'd4;

    localparam coord_t SIGMA_RST = 32'sd167772160;
    localparam coord_t RHO_RST   = 32'sd469762048;
    localparam coord_t BETA_RST  = 32'sd44739243;
    localparam logic [STEP_WIDTH-1:0] STEP_RST = 31'd167772;

    // operand file addresses; below A_HS are flops, the rest is RAM
    localparam addr_t A_PX = 5'd0;
    localparam addr_t A_PY = 5'd1;
    localparam addr_t A_PZ = 5'd2;
    localparam addr_t A_H  = 5'd3;
    localparam addr_t A_SG = 5'd4;
    localparam addr_t A_RH = 5'd5;
    localparam addr_t A_BT = 5'd6;
    localparam addr_t A_HS = 5'd7;
    localparam addr_t A_HB = 5'd8;
    localparam addr_t A_QX = 5'd9;
    localparam addr_t A_HX = 5'd12;
    localparam addr_t A_T0 = 5'd13;
    localparam addr_t A_T1 = 5'd14;
    localparam addr_t A_GA = 5'd15;
    localparam addr_t A_GB = 5'd18;
    localparam addr_t A_GC = 5'd21;
    localparam addr_t A_GD = 5'd24;

    localparam pc_t PC_LAST_EULER = 7'd14;
    localparam pc_t PC_LAST_RK4   = 7'd68;

    typedef enum logic [2:0] {
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_ADDH,
        OP_ADD6
    } op_t;

    typedef struct packed {
        op_t   op;
        addr_t a;
        addr_t b;
        addr_t dst;
    } uop_t;

    typedef struct packed {
        logic issue;
        uop_t uop;
        logic load;
        logic clr;
        logic capture;
    } lorenz_cmd_t;

    typedef struct packed {
        logic method;
    } lorenz_stat_t;

    typedef struct packed {
        logic   sat;
        coord_t v;
    } sres_t;

    function automatic sres_t clamp_sum(input logic signed [COORD_WIDTH:0] s);
        sres_t r;
        if (s[COORD_WIDTH] != s[COORD_WIDTH-1])
        begin
            r.sat = 1'b1;
            r.v   = s[COORD_WIDTH] ? COORD_MIN : COORD_MAX;
        end
        else
        begin
            r.sat = 1'b0;
            r.v   = s[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic uop_t mk(input op_t op, input addr_t a, input addr_t b,
                                input addr_t dst);
        uop_t u;
        u.op  = op;
        u.a   = a;
        u.b   = b;
        u.dst = dst;
        return u;
    endfunction

    // scaled derivative g = h*f(p) of point at xb, written to gb
    function automatic uop_t incr_op(input logic [3:0] k, input addr_t xb,
                                     input addr_t gb);
        uop_t u;
        unique case (k)
            4'd0:    u = mk(OP_MUL, A_H,  xb,          A_HX);
            4'd1:    u = mk(OP_SUB, xb + 5'd1, xb,     A_T0);
            4'd2:    u = mk(OP_MUL, A_HS, A_T0,        gb);
            4'd3:    u = mk(OP_SUB, A_RH, xb + 5'd2,   A_T0);
            4'd4:    u = mk(OP_MUL, A_HX, A_T0,        A_T1);
            4'd5:    u = mk(OP_MUL, A_H,  xb + 5'd1,   A_T0);
            4'd6:    u = mk(OP_SUB, A_T1, A_T0,        gb + 5'd1);
            4'd7:    u = mk(OP_MUL, A_HX, xb + 5'd1,   A_T1);
            4'd8:    u = mk(OP_MUL, A_HB, xb + 5'd2,   A_T0);
            4'd9:    u = mk(OP_SUB, A_T1, A_T0,        gb + 5'd2);
            default: u = mk(OP_ADD, A_T0, A_T0,        A_T0);
        endcase
        return u;
    endfunction

    // final weighted sum of one coordinate
    function automatic uop_t fin_op(input logic [2:0] j, input addr_t i);
        uop_t u;
        unique case (j)
            3'd0:    u = mk(OP_ADD,  A_GA + i, A_GD + i, A_T0);
            3'd1:    u = mk(OP_ADD,  A_T0, A_GB + i, A_T0);
            3'd2:    u = mk(OP_ADD,  A_T0, A_GB + i, A_T0);
            3'd3:    u = mk(OP_ADD,  A_T0, A_GC + i, A_T0);
            3'd4:    u = mk(OP_ADD,  A_T0, A_GC + i, A_T0);
            3'd5:    u = mk(OP_ADD6, A_PX + i, A_T0, A_PX + i);
            default: u = mk(OP_ADD,  A_T0, A_T0, A_T0);
        endcase
        return u;
    endfunction

    function automatic uop_t ucode(input pc_t pc, input logic method);
        uop_t  u;
        pc_t   o;
        addr_t i;
        o = '0;
        i = '0;
        priority if (pc == 7'd0)
            u = mk(OP_MUL, A_H, A_SG, A_HS);
        else if (pc == 7'd1)
            u = mk(OP_MUL, A_H, A_BT, A_HB);
        else if (pc < 7'd12)
        begin
            o = pc - 7'd2;
            u = incr_op(o[3:0], A_PX, A_GA);
        end
        else if (pc < 7'd15)
        begin
            o = pc - 7'd12;
            i = {3'b000, o[1:0]};
            u = (method == METHOD_EULER) ? mk(OP_ADD, A_PX + i, A_GA + i, A_PX + i)
                                         : mk(OP_ADDH, A_PX + i, A_GA + i, A_QX + i);
        end
        else if (pc < 7'd25)
        begin
            o = pc - 7'd15;
            u = incr_op(o[3:0], A_QX, A_GB);
        end
        else if (pc < 7'd28)
        begin
            o = pc - 7'd25;
            i = {3'b000, o[1:0]};
            u = mk(OP_ADDH, A_PX + i, A_GB + i, A_QX + i);
        end
        else if (pc < 7'd38)
        begin
            o = pc - 7'd28;
            u = incr_op(o[3:0], A_QX, A_GC);
        end
        else if (pc < 7'd41)
        begin
            o = pc - 7'd38;
            i = {3'b000, o[1:0]};
            u = mk(OP_ADD, A_PX + i, A_GC + i, A_QX + i);
        end
        else if (pc < 7'd51)
        begin
            o = pc - 7'd41;
            u = incr_op(o[3:0], A_QX, A_GD);
        end
        else if (pc < 7'd57)
        begin
            o = pc - 7'd51;
            u = fin_op(o[2:0], 5'd0);
        end
        else if (pc < 7'd63)
        begin
            o = pc - 7'd57;
            u = fin_op(o[2:0], 5'd1);
        end
        else
        begin
            o = pc - 7'd63;
            u = fin_op(o[2:0], 5'd2);
        end
        return u;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/lorenz_if.sv]
// Valid/ready channel interfaces for request and result of the integrator.
// Depends on lorenz_pkg for the coordinate type.
`default_nettype none
interface lorenz_in_if
    import lorenz_pkg::*;
;
    logic   valid;
    logic   ready;
    logic   operation;
    coord_t load_x;
    coord_t load_y;
    coord_t load_z;
    modport source (output valid, operation, load_x, load_y, load_z, input ready);
    modport sink   (input valid, operation, load_x, load_y, load_z, output ready);
endinterface

interface lorenz_out_if
    import lorenz_pkg::*;
;
    logic   valid;
    logic   ready;
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   saturated;
    modport source (output valid, out_x, out_y, out_z, saturated, input ready);
    modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface
`default_nettype wire

[hw/rtl/lorenz_datapath.sv]
// Operand file, shared multiplier/adder unit, config and output registers.
// Depends on lorenz_pkg; driven by lorenz_ctrl through lorenz_cmd_t.
`default_nettype none
module lorenz_datapath
    import lorenz_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire lorenz_cmd_t              cmd,
    output lorenz_stat_t                  stat,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  wire logic [COORD_WIDTH-1:0]   cfg_data,
    input  wire coord_t                   load_x,
    input  wire coord_t                   load_y,
    input  wire coord_t                   load_z,
    output coord_t                        out_x,
    output coord_t                        out_y,
    output coord_t                        out_z,
    output logic                          saturated
);

    coord_t sigma_reg, rho_reg, beta_reg;
    logic [STEP_WIDTH-1:0] step_reg;
    logic method_reg;
    coord_t px_reg, py_reg, pz_reg;
    coord_t mem [2**ADDR_WIDTH];

    logic   e_vld_reg;
    op_t    e_op_reg;
    addr_t  e_a_reg, e_b_reg, e_dst_reg;
    coord_t a_dat_reg, b_dat_reg;
    logic   r_vld_reg;
    addr_t  r_dst_reg;
    coord_t r_res_reg;
    logic   sat_reg;
    coord_t out_x_reg, out_y_reg, out_z_reg;
    logic   out_sat_reg;

    coord_t flop_a, flop_b, ea, eb, mul_a, q6;
    logic signed [PROD_WIDTH-1:0] prod;
    logic signed [MQ_WIDTH-1:0]   mq;
    sres_t  res;

    always_comb
    begin
        unique case (cmd.uop.a)
            A_PX:    flop_a = px_reg;
            A_PY:    flop_a = py_reg;
            A_PZ:    flop_a = pz_reg;
            A_H:     flop_a = {1'b0, step_reg};
            A_SG:    flop_a = sigma_reg;
            A_RH:    flop_a = rho_reg;
            A_BT:    flop_a = beta_reg;
            default: flop_a = '0;
        endcase
        unique case (cmd.uop.b)
            A_PX:    flop_b = px_reg;
            A_PY:    flop_b = py_reg;
            A_PZ:    flop_b = pz_reg;
            A_H:     flop_b = {1'b0, step_reg};
            A_SG:    flop_b = sigma_reg;
            A_RH:    flop_b = rho_reg;
            A_BT:    flop_b = beta_reg;
            default: flop_b = '0;
        endcase
    end

    // operand read stage
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            e_op_reg  <= cmd.uop.op;
            e_a_reg   <= cmd.uop.a;
            e_b_reg   <= cmd.uop.b;
            e_dst_reg <= cmd.uop.dst;
            a_dat_reg <= (cmd.uop.a < A_HS) ? flop_a : mem[cmd.uop.a];
            b_dat_reg <= (cmd.uop.b < A_HS) ? flop_b : mem[cmd.uop.b];
        end
    end

    // execute stage with bypass of the previous result
    always_comb
    begin
        ea    = (r_vld_reg && r_dst_reg == e_a_reg) ? r_res_reg : a_dat_reg;
        eb    = (r_vld_reg && r_dst_reg == e_b_reg) ? r_res_reg : b_dat_reg;
        mul_a = (e_op_reg == OP_ADD6) ? DIV6_MAGIC : ea;
        prod  = mul_a * eb;
        mq    = prod[PROD_WIDTH-1:FRAC_BITS];
        q6    = prod[PROD_WIDTH-1:COORD_WIDTH] + {{(COORD_WIDTH-1){1'b0}}, eb[COORD_WIDTH-1]};
        unique case (e_op_reg)
            OP_MUL:
            begin
                if ((&mq[MQ_WIDTH-1:COORD_WIDTH-1]) || !(|mq[MQ_WIDTH-1:COORD_WIDTH-1]))
                begin
                    res.sat = 1'b0;
                    res.v   = mq[COORD_WIDTH-1:0];
                end
                else
                begin
                    res.sat = 1'b1;
                    res.v   = mq[MQ_WIDTH-1] ? COORD_MIN : COORD_MAX;
                end
            end
            OP_ADD:  res = clamp_sum({ea[COORD_WIDTH-1], ea} + {eb[COORD_WIDTH-1], eb});
            OP_SUB:  res = clamp_sum({ea[COORD_WIDTH-1], ea} - {eb[COORD_WIDTH-1], eb});
            OP_ADDH: res = clamp_sum({ea[COORD_WIDTH-1], ea}
                                     + {{2{eb[COORD_WIDTH-1]}}, eb[COORD_WIDTH-1:1]});
            OP_ADD6: res = clamp_sum({ea[COORD_WIDTH-1], ea} + {q6[COORD_WIDTH-1], q6});
            default: res = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (e_vld_reg && e_dst_reg >= A_HS)
        begin
            mem[e_dst_reg] <= res.v;
        end
    end

    always_ff @(posedge clk)
    begin
        r_dst_reg <= e_dst_reg;
        r_res_reg <= res.v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg  <= SIGMA_RST;
            rho_reg    <= RHO_RST;
            beta_reg   <= BETA_RST;
            step_reg   <= STEP_RST;
            method_reg <= METHOD_RK4;
            px_reg     <= '0;
            py_reg     <= '0;
            pz_reg     <= '0;
            e_vld_reg  <= 1'b0;
            r_vld_reg  <= 1'b0;
            sat_reg    <= 1'b0;
        end
        else
        begin
            e_vld_reg <= cmd.issue;
            r_vld_reg <= e_vld_reg;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SIGMA:  sigma_reg  <= cfg_data;
                    CFG_RHO:    rho_reg    <= cfg_data;
                    CFG_BETA:   beta_reg   <= cfg_data;
                    CFG_STEP:   step_reg   <= cfg_data[STEP_WIDTH-1:0];
                    CFG_METHOD: method_reg <= cfg_data[0];
                    default:    ;
                endcase
            end
            if (cmd.load)
            begin
                px_reg <= load_x;
                py_reg <= load_y;
                pz_reg <= load_z;
            end
            else if (e_vld_reg)
            begin
                if (e_dst_reg == A_PX)
                    px_reg <= res.v;
                if (e_dst_reg == A_PY)
                    py_reg <= res.v;
                if (e_dst_reg == A_PZ)
                    pz_reg <= res.v;
            end
            if (cmd.clr)
                sat_reg <= 1'b0;
            else if (e_vld_reg && res.sat)
                sat_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            out_x_reg   <= px_reg;
            out_y_reg   <= py_reg;
            out_z_reg   <= pz_reg;
            out_sat_reg <= sat_reg;
        end
    end

    assign stat.method = method_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_z       = out_z_reg;
    assign saturated   = out_sat_reg;

endmodule
`default_nettype wire

[hw/rtl/lorenz_ctrl.sv]
// Sequencer: request handshake, microcode program counter, result handshake.
// Depends on lorenz_pkg; drives lorenz_datapath through lorenz_cmd_t.
`default_nettype none
module lorenz_ctrl
    import lorenz_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         in_operation,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    input  wire lorenz_stat_t stat,
    output lorenz_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg;
    pc_t    pc_reg;
    logic   in_ready_reg;
    logic   out_valid_reg;
    logic   accept;
    pc_t    pc_last;

    assign accept  = in_valid && in_ready_reg;
    assign pc_last = (stat.method == METHOD_EULER) ? PC_LAST_EULER : PC_LAST_RK4;

    always_comb
    begin
        cmd.issue   = (state_reg == ST_RUN);
        cmd.uop     = ucode(pc_reg, stat.method);
        cmd.load    = accept && (in_operation == OPER_LOAD);
        cmd.clr     = accept;
        cmd.capture = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        in_ready_reg <= 1'b0;
                        pc_reg       <= '0;
                        state_reg    <= (in_operation == OPER_STEP) ? ST_RUN : ST_DONE;
                    end
                end
                ST_RUN:
                begin
                    pc_reg <= pc_reg + 7'd1;
                    if (pc_reg == pc_last)
                        state_reg <= ST_DRAIN;
                end
                ST_DRAIN:
                    state_reg <= ST_DONE;
                ST_DONE:
                begin
                    if (cmd.capture)
                    begin
                        in_ready_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

[hw/rtl/lorenz_ode_integrator_unit.sv]
// Lorenz system integrator, Q8.24 fixed point, Euler or RK4 per step.
// Depends on lorenz_pkg, lorenz_in_if/lorenz_out_if, lorenz_ctrl, lorenz_datapath.
//
// Usage: requests arrive on in_ch (valid/ready). operation LOAD sets the point
// to load_x/y/z; operation STEP advances it by one step h. Every request
// yields exactly one result on out_ch: the point after it and a sticky flag
// that is set when any intermediate value clipped.
// Configuration (sigma, rho, beta, step_size, method) is written through
// cfg_we/cfg_index/cfg_data while no request is in flight.
// Timing: a step runs a microprogram on one shared multiply/add unit, one
// operation per cycle: 15 operations for Euler, 69 for RK4. A load request
// goes straight to the output register; a step first runs its microprogram
// and drains the pipeline. One request is in flight at a time; in_ch.ready
// rises together with the result entering the output register.
// Reset: point cleared to zero, registers to their defaults, channels idle.
// Stall: a finished result waits in the output register until taken; the
// block accepts the next request while that result is still held, and a
// later result waits for the slot to free.
`default_nettype none
module lorenz_ode_integrator_unit
    import lorenz_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    lorenz_in_if.sink                     in_ch,
    lorenz_out_if.source                  out_ch,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  wire logic [COORD_WIDTH-1:0]   cfg_data
);

    lorenz_cmd_t  cmd;
    lorenz_stat_t stat;

    lorenz_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_ch.valid),
        .in_operation (in_ch.operation),
        .in_ready     (in_ch.ready),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    lorenz_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .load_x    (in_ch.load_x),
        .load_y    (in_ch.load_y),
        .load_z    (in_ch.load_z),
        .out_x     (out_ch.out_x),
        .out_y     (out_ch.out_y),
        .out_z     (out_ch.out_z),
        .saturated (out_ch.saturated)
    );

endmodule
`default_nettype wire

[hw/rtl/lorenz_checker.sv]
// Port-level checks of the integrator handshakes, bound to the top level.
// Depends on lorenz_pkg and lorenz_ode_integrator_unit.
`default_nettype none
module lorenz_checker
    import lorenz_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    input wire logic   in_valid,
    input wire logic   in_ready,
    input wire logic   out_valid,
    input wire logic   out_ready,
    input wire coord_t out_x,
    input wire logic   saturated
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(saturated))
        else $error("result dropped or changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while one is in flight");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early after request");

    a_result_before_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> out_valid)
        else $error("request port reopened without a result");

endmodule

bind lorenz_ode_integrator_unit lorenz_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_x     (out_ch.out_x),
    .saturated (out_ch.saturated)
);
`default_nettype wire
